// ----- hdl/vlbp_pkg.sv -----
// Shared constants and types for the variable-length bit packer.
package vlbp_pkg;

  localparam int WORD_BITS = 64;
  localparam int CNT_W = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic [CNT_W-1:0]     bits;
    logic                 msb_first;
  } field_t;

  typedef struct packed {
    logic   valid;
    field_t entry;
  } queue_head_t;

  localparam logic [CNT_W-1:0] FULL_WORD = CNT_W'(WORD_BITS);

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [CNT_W-1:0] n);
    return ~({WORD_BITS{1'b1}} << n);
  endfunction

endpackage

// ----- hdl/vlbp_front.sv -----
// Front end: accepts fields, saturates the count and drops empty fields.
module vlbp_front
  import vlbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] field_value,
  input  logic [CNT_W-1:0]     field_bits,
  input  logic                 queue_full,
  output logic                 push,
  output field_t               push_entry
);

  logic             msb_first;
  logic [CNT_W-1:0] sat_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      msb_first <= 1'b1;
    end else if (cfg_wr_en) begin
      msb_first <= cfg_wr_data;
    end
  end

  always_comb begin
    sat_bits = (field_bits > FULL_WORD) ? FULL_WORD : field_bits;
    in_stall = queue_full;
    push = in_valid && !queue_full && (sat_bits != '0);
    push_entry.value = field_value;
    push_entry.bits = sat_bits;
    push_entry.msb_first = msb_first;
  end

endmodule

// ----- hdl/vlbp_queue.sv -----
// Short queue of classified fields between the front end and the packer.
module vlbp_queue
  import vlbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  field_t      push_entry,
  output logic        full,
  input  logic        pop,
  output queue_head_t head
);

  field_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_comb begin
    full = (count == (QPTR_W+1)'(QUEUE_DEPTH));
    head.valid = (count != '0);
    head.entry = mem[rd_ptr];
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into a full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from an empty queue");
  assert property (@(posedge clk) disable iff (rst)
                   count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ----- hdl/vlbp_back.sv -----
// Back end: shifts fields into the accumulator and registers finished words.
module vlbp_back
  import vlbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  queue_head_t          head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] packed_word
);

  logic [WORD_BITS-1:0] acc;
  logic [CNT_W-1:0]     free;
  logic [WORD_BITS-1:0] acc_next;
  logic [CNT_W-1:0]     free_next;
  logic [WORD_BITS-1:0] word_c;
  logic [WORD_BITS-1:0] word_out;
  logic [WORD_BITS-1:0] base;
  logic [WORD_BITS-1:0] vsrc;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     frn;
  logic [CNT_W-1:0]     sh;
  logic                 msb;
  logic                 emit;

  function automatic logic [WORD_BITS-1:0] swap_bytes(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS / 8; i++) begin
      r[8*i +: 8] = x[WORD_BITS-8-8*i +: 8];
    end
    return r;
  endfunction

  always_comb begin
    n = head.entry.bits;
    msb = head.entry.msb_first;
    emit = (n >= free);
    if (msb) begin
      word_c = acc | ((head.entry.value >> (n - free)) & low_mask(free));
    end else begin
      word_c = acc | (head.entry.value << (FULL_WORD - free));
    end
    word_out = msb ? swap_bytes(word_c) : word_c;
    rem = emit ? (n - free) : n;
    frn = emit ? FULL_WORD : free;
    base = emit ? '0 : acc;
    vsrc = (emit && !msb) ? (head.entry.value >> free) : head.entry.value;
    sh = msb ? (frn - rem) : (FULL_WORD - frn);
    acc_next = base | ((vsrc & low_mask(rem)) << sh);
    free_next = frn - rem;
    pop = head.valid && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      free <= FULL_WORD;
      out_valid <= 1'b0;
    end else if (pop) begin
      acc <= acc_next;
      free <= free_next;
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      packed_word <= word_out;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   (free != '0) && (free <= FULL_WORD))
    else $error("free bit count out of range");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && out_stall |-> !pop)
    else $error("field consumed while a word is stalled");
  assert property (@(posedge clk) disable iff (rst)
                   pop && emit |=> out_valid)
    else $error("finished word not presented");

endmodule

// ----- hdl/variable_length_bit_packer.sv -----
// Top level of the variable-length bit packer.
// A field that completes a word is queued, then the word is registered by the back end.
// Throughput: one field per cycle unless a word stalls; one barrel shift and merge each.
// A stalled output word holds the back end, and the four-entry queue keeps the input open.
// Reset: accumulator cleared, 64 free bits, msb_first set to 1, queue emptied.
module variable_length_bit_packer
  import vlbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] field_value,
  input  logic [CNT_W-1:0]     field_bits,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] packed_word
);

  logic        push;
  field_t      push_entry;
  logic        queue_full;
  logic        pop;
  queue_head_t head;

  vlbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .field_value (field_value),
    .field_bits  (field_bits),
    .queue_full  (queue_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  vlbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head)
  );

  vlbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packed_word (packed_word)
  );

endmodule

// ----- verif/variable_length_bit_packer_tb.sv -----
// Self-checking testbench for the variable-length bit packer, with its own packing predictor.
module variable_length_bit_packer_tb;
  import vlbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [WORD_BITS-1:0] value;
    logic [CNT_W-1:0]     bits;
  } field_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_wr_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [WORD_BITS-1:0] field_value = '0;
  logic [CNT_W-1:0]     field_bits = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_BITS-1:0] packed_word;

  field_beat_t          pending_fields[$];
  logic [WORD_BITS-1:0] expected_words[$];

  logic [WORD_BITS-1:0] acc_bits = '0;
  int                   free_left = WORD_BITS;
  logic                 msb_mode = 1'b1;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_arm = 1'b0;
  int cycle_cnt = 0;
  int errors = 0;
  int beats_in = 0;
  int words_checked = 0;
  int mode_writes = 0;
  logic [WORD_BITS-1:0] want_word;

  variable_length_bit_packer u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .field_value (field_value),
    .field_bits  (field_bits),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packed_word (packed_word)
  );

  always #6 clk = ~clk;

  function automatic logic [WORD_BITS-1:0] word_mask(input int n);
    if (n >= WORD_BITS) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic logic [WORD_BITS-1:0] byte_swap(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r = {r[WORD_BITS-9:0], x[7:0]};
      x = x >> 8;
    end
    return r;
  endfunction

  function automatic void pack_field(input logic [WORD_BITS-1:0] v, input logic [CNT_W-1:0] nb);
    int n;
    int fr;
    logic [WORD_BITS-1:0] val;
    n = (nb > WORD_BITS) ? WORD_BITS : int'(nb);
    fr = free_left;
    val = v;
    if (n == 0) return;
    if (msb_mode) begin
      if (n >= fr) begin
        acc_bits |= (val >> (n - fr)) & word_mask(fr);
        expected_words.push_back(byte_swap(acc_bits));
        n -= fr;
        acc_bits = '0;
        fr = WORD_BITS;
      end
      if (n > 0) begin
        acc_bits |= (val & word_mask(n)) << (fr - n);
        fr -= n;
      end
    end else begin
      if (n >= fr) begin
        acc_bits |= val << (WORD_BITS - fr);
        expected_words.push_back(acc_bits);
        val = (fr < WORD_BITS) ? (val >> fr) : '0;
        n -= fr;
        acc_bits = '0;
        fr = WORD_BITS;
      end
      if (n > 0) begin
        acc_bits |= (val & word_mask(n)) << (WORD_BITS - fr);
        fr -= n;
      end
    end
    free_left = fr;
  endfunction

  function automatic void push_field(input logic [WORD_BITS-1:0] v, input logic [CNT_W-1:0] b);
    field_beat_t f;
    f.value = v;
    f.bits = b;
    pending_fields.push_back(f);
  endfunction

  function automatic void push_random(input int count);
    logic [WORD_BITS-1:0] v;
    logic [CNT_W-1:0] b;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 5) b = '0;
      else if (r < 11) b = CNT_W'(WORD_BITS);
      else if (r < 14) b = CNT_W'($urandom_range(127, 65));
      else if (r < 50) b = CNT_W'($urandom_range(8, 1));
      else b = CNT_W'($urandom_range(63, 1));
      r = $urandom_range(99);
      if (r < 5) v = '0;
      else if (r < 10) v = '1;
      else v = {$urandom, $urandom};
      push_field(v, b);
    end
  endfunction

  task automatic wait_idle();
    @(posedge clk);
    #1;
    while (pending_fields.size() != 0 || in_valid || expected_words.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    msb_mode = m;
    mode_writes++;
  endtask

  // Sender: holds a stalled beat, otherwise offers the next pending field or idles.
  always @(posedge clk) begin
    field_beat_t f;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pack_field(field_value, field_bits);
        beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_fields.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          f = pending_fields.pop_front();
          in_valid <= 1'b1;
          field_value <= f.value;
          field_bits <= f.bits;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted beat against the oldest expected word.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: packed_word expected none, actual %h", $time, packed_word);
          errors++;
        end else begin
          want_word = expected_words.pop_front();
          words_checked++;
          if (packed_word !== want_word) begin
            $display("%0t: packed_word expected %h, actual %h", $time, want_word, packed_word);
            errors++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long receiver hold-off so that the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
      hold_arm <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[variable_length_bit_packer] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // MSB-first from reset: zero count, full words, split fields, saturated counts.
    push_field('1, 7'd0);
    push_field('1, 7'd64);
    push_field('0, 7'd64);
    push_field(64'd1, 7'd1);
    push_field(64'h5555_5555_5555_5555, 7'd63);
    push_field('1, 7'd7);
    push_field(64'h0123_4567_89ab_cdef, 7'd65);
    push_field({$urandom, $urandom}, 7'd127);
    push_field('0, 7'd0);
    push_field(64'hfedc_ba98_7654_3210, 7'd57);
    push_field(64'hdead_beef_cafe_f00d, 7'd13);
    // Switch to LSB-first while bits are still held.
    write_mode(1'b0);
    push_field('1, 7'd0);
    push_field(64'h8000_0000_0000_0001, 7'd64);
    push_field('1, 7'd64);
    push_field('0, 7'd1);
    push_field('1, 7'd63);
    push_field(64'hffff_ffff_ffff_fff0, 7'd4);
    push_field(64'h0f0f_0f0f_0f0f_0f0f, 7'd100);
    push_field('0, 7'd64);
    push_field({$urandom, $urandom}, 7'd33);
    push_field(64'haaaa_aaaa_aaaa_aaaa, 7'd31);
    push_field('1, 7'd127);
    write_mode(1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 26 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        write_mode(logic'((seg + phase) % 2));
        if (phase == 2 && seg == 1) begin
          hold_arm = 1'b1;
          push_random(80);
        end else begin
          push_random(50);
        end
      end
    end

    wait_idle();
    if (expected_words.size() != 0) begin
      $display("%0t: %0d packed words expected but never seen", $time, expected_words.size());
      errors++;
    end
    $display("Sent %0d field beats and checked %0d packed words across %0d mode writes.",
             beats_in, words_checked, mode_writes);
    $display("Covered both bit orders, zero and saturated counts, idle mixes and a long stall.");
    if (errors == 0) begin
      $display("[variable_length_bit_packer] OK");
    end else begin
      $display("[variable_length_bit_packer] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/vlbp_pkg.sv
hdl/vlbp_front.sv
hdl/vlbp_queue.sv
hdl/vlbp_back.sv
hdl/variable_length_bit_packer.sv
verif/variable_length_bit_packer_tb.sv
